[src/gha_pkg.sv]
// gha_pkg: shared types and constants for the generational handle allocator.
// Depends on nothing; gha_ctrl, gha_dp, the top level and the bench import it.
package gha_pkg;

  // Table geometry: handles pack as {0, generation, index}.
  localparam int unsigned SLOTS  = 1024;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned HDL_W  = 32;
  // Generations stay below min(2^22, 2^31 / SLOTS), so they fit in GEN_W bits.
  localparam int unsigned GEN_W  = HDL_W - 1 - IDX_W;
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned FUNC_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_LOOKUP  = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctl_state_t;

  // One slot table word.
  typedef struct packed {
    logic             valid;
    logic [GEN_W-1:0] gen;
    logic [IDX_W-1:0] next_free;
  } slot_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the input beat and issue the slot read
    logic commit;   // update state and load the output register
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_blocked;  // output register holds a beat not yet taken
  } dp_status_t;

endpackage

[src/gha_if.sv]
// gha_if: valid/ready channel interfaces for request and result beats.
// Depends on nothing.
interface gha_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [31:0] handle;

  modport source (output valid, output func, output handle, input ready);
  modport sink   (input valid, input func, input handle, output ready);
endinterface

interface gha_out_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] result_handle;
  logic [9:0]         slot_index;

  modport source (output valid, output ok, output result_handle, output slot_index,
                  input ready);
  modport sink   (input valid, input ok, input result_handle, input slot_index,
                  output ready);
endinterface

[src/gha_ctrl.sv]
// gha_ctrl: two-state controller sequencing capture/read and commit.
// Depends on gha_pkg.
module gha_ctrl
  import gha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dp_status_t status,
  output logic       in_ready,
  output ctl_cmd_t   cmd
);

  ctl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!status.out_blocked) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.commit = !status.out_blocked;
      end
      default: ;
    endcase
  end

endmodule

[src/gha_dp.sv]
// gha_dp: slot table memory, free list and high mark, generation counter,
// result register. Depends on gha_pkg.
module gha_dp
  import gha_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_cmd_t                cmd,
  output dp_status_t              status,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic signed [HDL_W-1:0] in_handle,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_ok,
  output logic signed [HDL_W-1:0] out_result_handle,
  output logic [9:0]              out_slot_index
);

  // Slot table: only entries at or below the high mark are ever read as live,
  // and each of those was written since the last clear, so no clearing sweep.
  slot_entry_t mem [SLOTS];
  slot_entry_t rd_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_entry_t      wr_data;

  // Captured request
  func_t            func_r;
  logic [HDL_W-1:0] handle_r;

  // Allocator state
  logic             hu_valid_r, hu_valid_nxt;
  logic [IDX_W-1:0] hu_r, hu_nxt;
  logic [IDX_W-1:0] free_head_r, free_head_nxt;
  logic [CNT_W-1:0] free_count_r, free_count_nxt;
  logic [GEN_W-1:0] gen_r, gen_nxt;

  // Output register
  logic             out_valid_r;
  logic             ok_r, ok_nxt;
  logic [HDL_W-1:0] res_r, res_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             full;
  logic [IDX_W-1:0] hdl_idx;
  logic [GEN_W:0]   hdl_gen;   // generation part including the top bit
  logic             match;

  // Read address: allocate pops the free-list head, others address by handle
  assign rd_addr = (func_t'(in_func) == FUNC_ALLOC) ? free_head_r
                                                     : in_handle[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.capture) rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r   <= func_t'(in_func);
      handle_r <= in_handle;
    end
  end

  // Handle split and match check
  assign hdl_idx = handle_r[IDX_W-1:0];
  assign hdl_gen = handle_r[HDL_W-1:IDX_W];
  assign match   = hu_valid_r && (hdl_idx <= hu_r) && rd_r.valid &&
                   ((hdl_gen == '0) || (hdl_gen == {1'b0, rd_r.gen}));
  assign full    = hu_valid_r && (hu_r == IDX_W'(SLOTS - 1)) && (free_count_r == '0);

  // Operation logic, applied on commit
  always_comb begin
    hu_valid_nxt   = hu_valid_r;
    hu_nxt         = hu_r;
    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    gen_nxt        = gen_r;
    ok_nxt         = 1'b0;
    res_nxt        = '1;
    idx_nxt        = '0;
    wr_en          = 1'b0;
    wr_addr        = hdl_idx;
    wr_data        = rd_r;
    case (func_r)
      FUNC_ALLOC: begin
        if (!full) begin
          if (free_count_r != '0) begin
            idx_nxt        = free_head_r;
            free_head_nxt  = rd_r.next_free;
            free_count_nxt = free_count_r - 1'b1;
          end else begin
            idx_nxt      = hu_valid_r ? hu_r + 1'b1 : '0;
            hu_valid_nxt = 1'b1;
            hu_nxt       = idx_nxt;
          end
          wr_en             = 1'b1;
          wr_addr           = idx_nxt;
          wr_data.valid     = 1'b1;
          wr_data.gen       = gen_r;
          wr_data.next_free = '0;
          ok_nxt            = 1'b1;
          res_nxt           = {1'b0, gen_r, idx_nxt};
          // generation wraps to one, never zero
          gen_nxt = (gen_r == '1) ? GEN_W'(1) : gen_r + 1'b1;
        end
      end
      FUNC_LOOKUP, FUNC_RELEASE: begin
        if (match) begin
          ok_nxt  = 1'b1;
          idx_nxt = hdl_idx;
          res_nxt = {1'b0, rd_r.gen, hdl_idx};
          if (func_r == FUNC_RELEASE) begin
            wr_en             = 1'b1;
            wr_data.valid     = 1'b0;
            wr_data.next_free = free_head_r;
            free_head_nxt     = hdl_idx;
            free_count_nxt    = free_count_r + 1'b1;
          end
        end
      end
      default: begin
        // clear all: generation survives
        hu_valid_nxt   = 1'b0;
        free_count_nxt = '0;
      end
    endcase
    if (!cmd.commit) wr_en = 1'b0;
  end

  // Allocator state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hu_valid_r   <= 1'b0;
      hu_r         <= '0;
      free_head_r  <= '0;
      free_count_r <= '0;
      gen_r        <= GEN_W'(1);
    end else if (cmd.commit) begin
      hu_valid_r   <= hu_valid_nxt;
      hu_r         <= hu_nxt;
      free_head_r  <= free_head_nxt;
      free_count_r <= free_count_nxt;
      gen_r        <= gen_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok_r  <= ok_nxt;
      res_r <= res_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign status.out_blocked = out_valid_r && !out_ready;
  assign out_valid          = out_valid_r;
  assign out_ok             = ok_r;
  assign out_result_handle  = res_r;
  assign out_slot_index     = 10'(idx_r);

endmodule

[src/generational_handle_allocator.sv]
// generational_handle_allocator: top level joining controller and datapath.
// Depends on gha_pkg, gha_if, gha_ctrl, gha_dp.
//
//  channel   dir  beat fields                       handshake
//  in_ch     in   func[1:0], handle[31:0] signed    valid/ready
//  out_ch    out  ok, result_handle[31:0], slot_index[9:0]  valid/ready
//
// Each request is handled in ST_IDLE, which latches it and reads its slot word from the
// single-port 1024-entry table, then in ST_EXEC, which updates the table and loads the result.
// A new request is taken while the previous result sits in the output register;
// it stalls in ST_EXEC only if that register is still unclaimed.
// Reset (synchronous, rst_n low) empties the table at once; no sweep is needed.
module generational_handle_allocator
  import gha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gha_in_if.sink     in_ch,
  gha_out_if.source  out_ch
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  gha_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_func           (in_ch.func),
    .in_handle         (in_ch.handle),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ok            (out_ch.ok),
    .out_result_handle (out_ch.result_handle),
    .out_slot_index    (out_ch.slot_index)
  );

endmodule

[dv/tb_generational_handle_allocator.sv]
`timescale 1ns / 1ps
// tb_generational_handle_allocator: self-checking bench for the handle allocator.
// Depends on gha_pkg, gha_if and the RTL; predicts every result beat in-bench.
module tb_generational_handle_allocator;
  import gha_pkg::*;

  localparam int unsigned GEN_LIMIT = ((32'h8000_0000 / SLOTS) < (1 << 22)) ?
                                      (32'h8000_0000 / SLOTS) : (1 << 22);
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 200;
  localparam logic [31:0] BAD_HANDLE = 32'hFFFF_FFFF;

  typedef struct {
    logic        ok;
    logic [31:0] hdl;
    logic [9:0]  idx;
  } reply_t;

  logic clk;
  logic rst_n;

  gha_in_if  in_ch ();
  gha_out_if out_ch ();

  generational_handle_allocator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the slot table
  bit          slot_live [SLOTS];
  logic [31:0] slot_hdl  [SLOTS];
  int          slot_link [SLOTS];
  int          high_mark;
  int          free_top;
  int          free_cnt;
  int unsigned gen_now;
  int          ever_top;   // highest slot ever written since reset

  reply_t pending_replies[$];
  int     bad_beats;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_req;
  int     hold_ack;
  int     hold_left;
  int     quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor: applies one request to the shadow table and returns its result
  function automatic reply_t table_apply(func_t f, logic [31:0] h);
    reply_t      r;
    int unsigned i;
    int unsigned g;
    int          n;
    r.ok  = 1'b0;
    r.hdl = BAD_HANDLE;
    r.idx = '0;
    case (f)
      FUNC_ALLOC: begin
        if (!(high_mark == int'(SLOTS) - 1 && free_cnt == 0)) begin
          if (free_cnt > 0) begin
            n        = free_top;
            free_top = slot_link[n];
            free_cnt--;
          end else begin
            high_mark++;
            n = high_mark;
          end
          slot_live[n] = 1'b1;
          slot_link[n] = -1;
          slot_hdl[n]  = gen_now * SLOTS + n;
          if (n > ever_top) ever_top = n;
          r.ok  = 1'b1;
          r.hdl = slot_hdl[n];
          r.idx = n[9:0];
          gen_now++;
          if (gen_now >= GEN_LIMIT) gen_now = 1;
        end
      end
      FUNC_LOOKUP, FUNC_RELEASE: begin
        if (h != BAD_HANDLE) begin
          i = h % SLOTS;
          g = h / SLOTS;
          if (high_mark >= 0 && int'(i) <= high_mark && slot_live[i] &&
              (g == 0 || slot_hdl[i] == h)) begin
            r.ok  = 1'b1;
            r.hdl = slot_hdl[i];
            r.idx = i[9:0];
            if (f == FUNC_RELEASE) begin
              slot_live[i] = 1'b0;
              slot_link[i] = free_top;
              free_top     = i;
              free_cnt++;
            end
          end
        end
      end
      default: begin
        for (int k = 0; k < int'(SLOTS); k++) begin
          slot_live[k] = 1'b0;
          slot_link[k] = -1;
        end
        high_mark = -1;
        free_top  = -1;
        free_cnt  = 0;
      end
    endcase
    return r;
  endfunction

  // Offers one request beat, records its expected result once it is taken
  task automatic send_req(func_t f, logic [31:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= f;
    in_ch.handle <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_replies.push_back(table_apply(f, h));
  endtask

  // Sender pause: nothing offered until every pending result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Handle mix for lookup/release: recorded, gen-zero, invalid, previous-gen, random upper bits
  function automatic logic [31:0] pick_handle();
    int unsigned k;
    int unsigned i;
    logic [31:0] h;
    k = $urandom_range(99);
    i = $urandom_range(ever_top);
    h = $urandom;
    if (k < 45 && high_mark >= 0) h = slot_hdl[$urandom_range(high_mark)];
    else if (k < 45)              h = slot_hdl[i];
    else if (k < 60)              h = i;
    else if (k < 68)              h = BAD_HANDLE;
    else if (k < 78)              h = (gen_now - 1) * SLOTS + i;
    else                          h[IDX_W-1:0] = i[IDX_W-1:0];
    return h;
  endfunction

  // Allocate, lookups, release, free-list reuse, clear and high-mark checks
  task automatic test_directed_basics();
    logic [31:0] h0;
    logic [31:0] h1;
    logic [31:0] h3;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_req(FUNC_ALLOC, '0);
    h0 = slot_hdl[0];
    send_req(FUNC_ALLOC, '0);
    h1 = slot_hdl[1];
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_LOOKUP, h1);
    send_req(FUNC_LOOKUP, 32'd1);            // generation part zero matches any
    send_req(FUNC_LOOKUP, h1 + SLOTS);       // wrong generation
    send_req(FUNC_RELEASE, h0);
    send_req(FUNC_RELEASE, h0);              // double release
    send_req(FUNC_LOOKUP, h0);               // stale handle
    send_req(FUNC_ALLOC, '0);                // reuses slot 0
    send_req(FUNC_RELEASE, h1);
    send_req(FUNC_RELEASE, 32'd2);           // release by index only
    send_req(FUNC_ALLOC, '0);                // LIFO: slot 2 first
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);                // fresh slot 3
    h3 = slot_hdl[3];
    send_req(FUNC_CLEAR, '0);
    send_req(FUNC_LOOKUP, h3);               // nothing in use after clear
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_LOOKUP, h3);               // index above high mark
    send_req(FUNC_RELEASE, 32'd3);
    send_req(FUNC_LOOKUP, slot_hdl[0]);
    wait_drained();
  endtask

  // Fill every slot, fail on a full table, then cycle a few through the free list
  task automatic test_table_full();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_req(FUNC_CLEAR, '0);
    for (int k = 0; k < int'(SLOTS); k++) send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_LOOKUP, slot_hdl[SLOTS-1]);
    send_req(FUNC_LOOKUP, BAD_HANDLE);
    send_req(FUNC_RELEASE, slot_hdl[5]);
    send_req(FUNC_RELEASE, slot_hdl[SLOTS-1]);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    wait_drained();
  endtask

  // Invalid, negative and extreme handles against a small live table
  task automatic test_odd_handles();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_req(FUNC_CLEAR, '0);
    send_req(FUNC_LOOKUP, 32'd0);            // empty table
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_ALLOC, '0);
    send_req(FUNC_LOOKUP, BAD_HANDLE);
    send_req(FUNC_RELEASE, BAD_HANDLE);
    send_req(FUNC_LOOKUP, 32'h8000_0000);
    send_req(FUNC_RELEASE, 32'hFFFF_FC00);
    send_req(FUNC_LOOKUP, 32'h7FFF_FFFF);
    send_req(FUNC_LOOKUP, 32'h7FFF_FC01);
    send_req(FUNC_LOOKUP, 32'd0);
    send_req(FUNC_RELEASE, 32'd1);
    send_req(FUNC_LOOKUP, slot_hdl[1]);
    wait_drained();
  endtask

  // Random mix of all four operations under one idle/stall setting
  task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
    int unsigned k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < n_items; n++) begin
      k = $urandom_range(99);
      if (k < 42)      send_req(FUNC_ALLOC, $urandom);
      else if (k < 70) send_req(FUNC_LOOKUP, pick_handle());
      else if (k < 97) send_req(FUNC_RELEASE, pick_handle());
      else             send_req(FUNC_CLEAR, $urandom);
    end
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    for (int n = 0; n < 40; n++) begin
      if (n % 3 == 0) send_req(FUNC_ALLOC, '0);
      else            send_req(FUNC_LOOKUP, pick_handle());
    end
    wait_drained();
  endtask

  // Result side: random stalls plus the requested long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_ack     = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic note_mismatch(string what, reply_t exp, reply_t got);
    bad_beats++;
    if (bad_beats <= 10)
      $display("%0t: %s: expected ok=%0b handle=%0d slot=%0d, got ok=%0b handle=%0d slot=%0d",
               $realtime, what, exp.ok, $signed(exp.hdl), exp.idx,
               got.ok, $signed(got.hdl), got.idx);
  endtask

  // Result checker: every taken beat against the oldest prediction
  always @(posedge clk) begin
    reply_t got;
    reply_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.ok  = out_ch.ok;
      got.hdl = out_ch.result_handle;
      got.idx = out_ch.slot_index;
      if (pending_replies.size() == 0) begin
        exp.ok  = 1'bx;
        exp.hdl = 'x;
        exp.idx = 'x;
        note_mismatch("result beat with none pending", exp, got);
      end else begin
        exp = pending_replies.pop_front();
        if (got.ok !== exp.ok || got.hdl !== exp.hdl || got.idx !== exp.idx)
          note_mismatch("result mismatch", exp, got);
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_ALLOC;
    in_ch.handle   = '0;
    bad_beats      = 0;
    quiet_cycles   = 0;
    hold_req       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < int'(SLOTS); k++) begin
      slot_live[k] = 1'b0;
      slot_hdl[k]  = '0;
      slot_link[k] = -1;
    end
    high_mark = -1;
    free_top  = -1;
    free_cnt  = 0;
    gen_now   = 1;
    ever_top  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_table_full();
    test_odd_handles();
    test_random_traffic(60, 0, 0);
    test_random_traffic(60, 50, 0);
    test_random_traffic(60, 0, 50);
    test_random_traffic(60, 32, 32);
    test_backpressure();

    wait_drained();
    if (bad_beats == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/gha_pkg.sv
src/gha_if.sv
src/gha_ctrl.sv
src/gha_dp.sv
src/generational_handle_allocator.sv
dv/tb_generational_handle_allocator.sv
